FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MTC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define MTC_ASSERT(lbl, clk, rst_n, prop)
`define MTC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/mtc_pkg.sv
// Types, constants and the pattern matcher of the markup text cleaner.
`default_nettype none
package mtc_pkg;
    localparam int HOLD_DEPTH   = 128;
    localparam int PEEK_DEPTH   = 4;
    localparam int RESULT_LIMIT = 48;
    localparam int HOLD_BOUND   = 2 * RESULT_LIMIT - 2 * (PEEK_DEPTH + 1);
    localparam int HOLD_CAP     = (HOLD_DEPTH < HOLD_BOUND) ? HOLD_DEPTH : HOLD_BOUND;
    localparam int ADDR_W       = $clog2(HOLD_DEPTH);
    localparam int FILL_W       = $clog2(HOLD_CAP + 1);
    localparam int WORK_DEPTH   = PEEK_DEPTH + 1;
    localparam int POS_W        = $clog2(WORK_DEPTH + 1);
    localparam int PAT_LEN      = 5;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [6:0] WRAP_RESET = 7'd75;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_AMP     = "&";
    localparam logic [7:0] CH_LT      = "<";
    localparam logic [7:0] CH_GT      = ">";
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [PAT_LEN-1:0][7:0] PAT_AMP = {";", "p", "m", "a", "&"};
    localparam logic [PAT_LEN-1:0][7:0] PAT_LTE = {8'h00, ";", "t", "l", "&"};
    localparam logic [PAT_LEN-1:0][7:0] PAT_GTE = {8'h00, ";", "t", "g", "&"};
    localparam logic [PAT_LEN-1:0][7:0] PAT_BR  = {8'h00, ">", "r", "b", "<"};
    localparam logic [PAT_LEN-1:0][7:0] PAT_B   = {8'h00, 8'h00, ">", "b", "<"};

    typedef enum logic [1:0] {M_NO, M_YES, M_MORE} match_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [1:0] out_count;
        logic       out_end;
    } out_item_t;

    typedef struct packed {
        logic       is_end;
        logic       last;
        logic [7:0] data;
    } emit_t;

    function automatic match_t match_pat(input logic [PAT_LEN-1:0][7:0] v,
                                         input logic [POS_W-1:0] rem,
                                         input logic [PAT_LEN-1:0][7:0] pat,
                                         input logic [POS_W-1:0] len);
        logic       ok;
        logic [7:0] c;
        ok = 1'b1;
        for (int k = 0; k < PAT_LEN; k++)
        begin
            c = v[k];
            if (c >= "A" && c <= "Z")
                c = c + 8'd32;
            if (k < int'(len) && k < int'(rem) && c != pat[k])
                ok = 1'b0;
        end
        if (!ok)
            return M_NO;
        return (rem >= len) ? M_YES : M_MORE;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/mtc_front.sv
// Input side: takes transactions and queues them for the engine.
`default_nettype none
module mtc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mtc_pkg::in_item_t in_data,
    output logic                   q_valid,
    output mtc_pkg::in_item_t      q_data,
    input  wire logic              q_pop
);
    mtc_pkg::in_item_t                  q_mem [mtc_pkg::Q_DEPTH];
    logic [mtc_pkg::Q_PTR_W-1:0]        wp_reg;
    logic [mtc_pkg::Q_PTR_W-1:0]        rp_reg;
    logic [mtc_pkg::Q_CNT_W-1:0]        cnt_reg;
    logic                               push;
    logic                               pop;

    assign in_stall = (cnt_reg == mtc_pkg::Q_CNT_W'(mtc_pkg::Q_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = q_mem[rp_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mtc_engine.sv
// Back part: token scanner, hold buffer and word wrap sequencer.
`default_nettype none
module mtc_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [6:0]        cfg_data,
    input  wire logic              q_valid,
    input  wire mtc_pkg::in_item_t q_data,
    output logic                   q_pop,
    output logic                   emit_valid,
    output mtc_pkg::emit_t         emit,
    input  wire logic              emit_ready
);
    typedef enum logic [2:0] {S_IDLE, S_TOKEN, S_REL, S_POST, S_END} state_t;
    typedef enum logic [1:0] {MD_NORMAL, MD_TAG, MD_ENDED} mode_t;
    typedef enum logic [2:0] {P_NONE, P_SPACE, P_BYTE, P_NL, P_FIN} post_t;

    state_t                              state_reg;
    mode_t                               mode_reg;
    post_t                               post_reg;
    logic [6:0]                          wrap_reg;
    logic [7:0]                          w_reg [mtc_pkg::WORK_DEPTH];
    logic [7:0]                          peek_reg [mtc_pkg::PEEK_DEPTH];
    logic [mtc_pkg::POS_W-1:0]           wn_reg;
    logic [mtc_pkg::POS_W-1:0]           pos_reg;
    logic [mtc_pkg::POS_W-1:0]           pf_reg;
    logic                                last_reg;
    logic [7:0]                          col_reg;
    logic                                run_reg;
    logic                                pend_reg;
    logic [mtc_pkg::FILL_W-1:0]          fill_reg;
    logic [mtc_pkg::FILL_W-1:0]          ridx_reg;
    logic                                rnl_reg;
    logic [7:0]                          pc_reg;
    logic [1:0]                          nl_reg;

    logic [7:0]                          hold_mem [mtc_pkg::HOLD_DEPTH];
    logic [7:0]                          rdata_reg;
    logic                                wr_en;
    logic [mtc_pkg::ADDR_W-1:0]          wr_addr;
    logic [7:0]                          wr_data;
    logic [mtc_pkg::ADDR_W-1:0]          rd_addr;

    logic [mtc_pkg::PAT_LEN-1:0][7:0]    view;
    logic [mtc_pkg::POS_W-1:0]           rem;
    logic [7:0]                          b;
    logic                                blank;
    mtc_pkg::match_t                     s_amp, s_lt, s_gt, s_br, s_b;
    logic                                brk;
    logic                                tok_fin;
    logic [7:0]                          tc;
    logic [mtc_pkg::POS_W-1:0]           adv;
    logic                                wrap_now;
    logic                                hold_room;
    logic [1:0]                          tag_nl;
    logic [7:0]                          col_inc;
    logic [7:0]                          col_wrap;

    always_comb
    begin
        view = '0;
        for (int k = 0; k < mtc_pkg::PAT_LEN; k++)
            for (int j = 0; j < mtc_pkg::WORK_DEPTH; j++)
                if (j == int'(pos_reg) + k && j < int'(wn_reg))
                    view[k] = w_reg[j];
    end

    assign rem   = wn_reg - pos_reg;
    assign b     = view[0];
    assign blank = (b == mtc_pkg::CH_SPACE) || (b >= mtc_pkg::CH_TAB && b <= mtc_pkg::CH_CR);
    assign s_amp = mtc_pkg::match_pat(view, rem, mtc_pkg::PAT_AMP, mtc_pkg::POS_W'(5));
    assign s_lt  = mtc_pkg::match_pat(view, rem, mtc_pkg::PAT_LTE, mtc_pkg::POS_W'(4));
    assign s_gt  = mtc_pkg::match_pat(view, rem, mtc_pkg::PAT_GTE, mtc_pkg::POS_W'(4));
    assign s_br  = mtc_pkg::match_pat(view, rem, mtc_pkg::PAT_BR, mtc_pkg::POS_W'(4));
    assign s_b   = mtc_pkg::match_pat(view, rem, mtc_pkg::PAT_B, mtc_pkg::POS_W'(3));

    assign brk = (mode_reg == MD_NORMAL) && !last_reg &&
                 ((b == mtc_pkg::CH_AMP && (s_amp == mtc_pkg::M_MORE ||
                   s_lt == mtc_pkg::M_MORE || s_gt == mtc_pkg::M_MORE)) ||
                  (b == mtc_pkg::CH_LT && (s_br == mtc_pkg::M_MORE ||
                   s_b == mtc_pkg::M_MORE)));
    assign tok_fin   = (mode_reg == MD_ENDED) || (pos_reg >= wn_reg) || brk;
    assign wrap_now  = (col_reg > {1'b0, wrap_reg}) && pend_reg;
    assign hold_room = fill_reg < mtc_pkg::FILL_W'(mtc_pkg::HOLD_CAP);
    assign col_inc   = (col_reg == 8'hFF) ? col_reg : col_reg + 8'd1;
    assign col_wrap  = 8'(fill_reg - 1'b1);
    assign tag_nl    = (s_br == mtc_pkg::M_YES) ? 2'd1 : ((s_b == mtc_pkg::M_YES) ? 2'd2 : 2'd0);

    always_comb
    begin
        tc  = b;
        adv = mtc_pkg::POS_W'(1);
        if (b == mtc_pkg::CH_AMP)
        begin
            if (s_amp == mtc_pkg::M_YES)
                adv = mtc_pkg::POS_W'(5);
            else if (s_lt == mtc_pkg::M_YES)
            begin
                tc  = mtc_pkg::CH_LT;
                adv = mtc_pkg::POS_W'(4);
            end
            else if (s_gt == mtc_pkg::M_YES)
            begin
                tc  = mtc_pkg::CH_GT;
                adv = mtc_pkg::POS_W'(4);
            end
        end
    end

    // hold writes: fresh space, or a text byte appended after the pending space
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = mtc_pkg::CH_SPACE;
        if (state_reg == S_TOKEN && !tok_fin && mode_reg == MD_NORMAL && b != mtc_pkg::CH_NUL)
        begin
            if (blank)
                wr_en = !run_reg && !pend_reg;
            else if (b != mtc_pkg::CH_LT && !wrap_now && pend_reg && hold_room)
            begin
                wr_en   = 1'b1;
                wr_addr = mtc_pkg::ADDR_W'(fill_reg);
                wr_data = tc;
            end
        end
        else if (state_reg == S_POST && post_reg == P_SPACE)
            wr_en = 1'b1;
    end

    assign rd_addr = (state_reg == S_REL) ?
                     mtc_pkg::ADDR_W'(emit_ready ? ridx_reg + 1'b1 : ridx_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hold_mem[wr_addr] <= wr_data;
        rdata_reg <= hold_mem[rd_addr];
    end

    always_comb
    begin
        emit_valid  = 1'b0;
        emit.is_end = 1'b0;
        emit.last   = last_reg;
        emit.data   = pc_reg;
        unique case (state_reg)
            S_REL:
            begin
                emit_valid = 1'b1;
                emit.data  = (ridx_reg == '0 && rnl_reg) ? mtc_pkg::CH_NL : rdata_reg;
            end
            S_POST:
            begin
                emit_valid = (post_reg == P_BYTE) || (post_reg == P_NL);
                if (post_reg == P_NL)
                    emit.data = mtc_pkg::CH_NL;
            end
            S_END:
            begin
                emit_valid  = 1'b1;
                emit.is_end = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MD_NORMAL;
            post_reg  <= P_NONE;
            wrap_reg  <= mtc_pkg::WRAP_RESET;
            wn_reg    <= '0;
            pos_reg   <= '0;
            pf_reg    <= '0;
            last_reg  <= 1'b0;
            col_reg   <= '0;
            run_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
            ridx_reg  <= '0;
            rnl_reg   <= 1'b0;
            nl_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                wrap_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        for (int i = 0; i < mtc_pkg::PEEK_DEPTH; i++)
                            if (i < int'(pf_reg))
                                w_reg[i] <= peek_reg[i];
                            else
                                w_reg[i] <= q_data.in_byte;
                        w_reg[mtc_pkg::PEEK_DEPTH] <= q_data.in_byte;
                        wn_reg    <= (mode_reg == MD_ENDED) ? '0 : pf_reg + 1'b1;
                        pos_reg   <= '0;
                        last_reg  <= q_data.in_last;
                        state_reg <= S_TOKEN;
                    end
                end
                S_TOKEN:
                begin
                    ridx_reg <= '0;
                    rnl_reg  <= 1'b0;
                    if (tok_fin)
                    begin
                        for (int i = 0; i < mtc_pkg::PEEK_DEPTH; i++)
                            for (int j = 0; j < mtc_pkg::WORK_DEPTH; j++)
                                if (j == int'(pos_reg) + i)
                                    peek_reg[i] <= w_reg[j];
                        pf_reg <= (mode_reg == MD_ENDED || pos_reg >= wn_reg) ?
                                  '0 : wn_reg - pos_reg;
                        if (last_reg && pend_reg)
                        begin
                            post_reg  <= P_FIN;
                            state_reg <= S_REL;
                        end
                        else
                            state_reg <= S_END;
                    end
                    else if (mode_reg == MD_TAG)
                    begin
                        if (b == mtc_pkg::CH_NUL)
                            mode_reg <= MD_ENDED;
                        else if (b == mtc_pkg::CH_GT)
                            mode_reg <= MD_NORMAL;
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else if (b == mtc_pkg::CH_NUL)
                        mode_reg <= MD_ENDED;
                    else if (blank)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (!run_reg)
                        begin
                            run_reg <= 1'b1;
                            col_reg <= col_inc;
                            if (pend_reg)
                            begin
                                post_reg  <= P_SPACE;
                                state_reg <= S_REL;
                            end
                            else
                            begin
                                fill_reg <= mtc_pkg::FILL_W'(1);
                                pend_reg <= 1'b1;
                            end
                        end
                    end
                    else if (b == mtc_pkg::CH_LT)
                    begin
                        run_reg  <= 1'b0;
                        pos_reg  <= pos_reg + 1'b1;
                        mode_reg <= MD_TAG;
                        nl_reg   <= tag_nl;
                        post_reg <= (tag_nl != 2'd0) ? P_NL : P_NONE;
                        if (wrap_now)
                        begin
                            col_reg   <= col_wrap;
                            rnl_reg   <= 1'b1;
                            state_reg <= S_REL;
                        end
                        else if (tag_nl != 2'd0)
                            state_reg <= pend_reg ? S_REL : S_POST;
                    end
                    else
                    begin
                        run_reg <= 1'b0;
                        pos_reg <= pos_reg + adv;
                        pc_reg  <= tc;
                        if (wrap_now)
                        begin
                            col_reg   <= col_wrap;
                            rnl_reg   <= 1'b1;
                            post_reg  <= P_BYTE;
                            state_reg <= S_REL;
                        end
                        else if (pend_reg && hold_room)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            col_reg  <= col_inc;
                        end
                        else
                        begin
                            post_reg  <= P_BYTE;
                            state_reg <= pend_reg ? S_REL : S_POST;
                        end
                    end
                end
                S_REL:
                begin
                    if (emit_ready)
                    begin
                        ridx_reg <= ridx_reg + 1'b1;
                        if (ridx_reg == fill_reg - 1'b1)
                        begin
                            fill_reg <= '0;
                            pend_reg <= 1'b0;
                            priority case (post_reg)
                                P_NONE:  state_reg <= S_TOKEN;
                                P_FIN:   state_reg <= S_END;
                                default: state_reg <= S_POST;
                            endcase
                        end
                    end
                end
                S_POST:
                begin
                    unique case (post_reg)
                        P_SPACE:
                        begin
                            fill_reg  <= mtc_pkg::FILL_W'(1);
                            pend_reg  <= 1'b1;
                            state_reg <= S_TOKEN;
                        end
                        P_BYTE:
                        begin
                            if (emit_ready)
                            begin
                                col_reg   <= col_inc;
                                state_reg <= S_TOKEN;
                            end
                        end
                        P_NL:
                        begin
                            if (emit_ready)
                            begin
                                nl_reg <= nl_reg - 1'b1;
                                if (nl_reg == 2'd1)
                                begin
                                    col_reg   <= '0;
                                    state_reg <= S_TOKEN;
                                end
                            end
                        end
                        default: state_reg <= S_TOKEN;
                    endcase
                end
                S_END:
                begin
                    if (emit_ready)
                    begin
                        if (last_reg)
                        begin
                            fill_reg <= '0;
                            col_reg  <= '0;
                            run_reg  <= 1'b0;
                            pend_reg <= 1'b0;
                            pf_reg   <= '0;
                            mode_reg <= MD_NORMAL;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mtc_pack.sv
// Output side: pairs emitted bytes into result transactions.
`default_nettype none
module mtc_pack (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           emit_valid,
    input  wire mtc_pkg::emit_t emit,
    output logic                emit_ready,
    output logic                out_valid,
    input  wire logic           out_stall,
    output mtc_pkg::out_item_t  out_data
);
    logic                 ov_reg;
    mtc_pkg::out_item_t   od_reg;
    logic [7:0]           hb0_reg;
    logic [7:0]           hb1_reg;
    logic [1:0]           hc_reg;
    logic                 any_reg;
    logic                 take;

    assign emit_ready = !ov_reg || !out_stall;
    assign take       = emit_valid && emit_ready;
    assign out_valid  = ov_reg;
    assign out_data   = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            od_reg  <= '0;
            hb0_reg <= '0;
            hb1_reg <= '0;
            hc_reg  <= '0;
            any_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (take)
            begin
                if (!emit.is_end)
                begin
                    if (hc_reg == 2'd2)
                    begin
                        ov_reg  <= 1'b1;
                        od_reg  <= '{out_first: hb0_reg, out_second: hb1_reg,
                                     out_count: 2'd2, out_end: 1'b0};
                        hb0_reg <= emit.data;
                        hc_reg  <= 2'd1;
                        any_reg <= 1'b1;
                    end
                    else
                    begin
                        if (hc_reg == 2'd0)
                            hb0_reg <= emit.data;
                        else
                            hb1_reg <= emit.data;
                        hc_reg <= hc_reg + 2'd1;
                    end
                end
                else
                begin
                    if (hc_reg != 2'd0)
                    begin
                        ov_reg <= 1'b1;
                        od_reg <= '{out_first: hb0_reg,
                                    out_second: (hc_reg == 2'd2) ? hb1_reg : 8'h00,
                                    out_count: hc_reg, out_end: emit.last};
                    end
                    else if (emit.last && !any_reg)
                    begin
                        ov_reg <= 1'b1;
                        od_reg <= '{out_first: 8'h00, out_second: 8'h00,
                                    out_count: 2'd0, out_end: 1'b1};
                    end
                    hc_reg  <= '0;
                    any_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/markup_text_cleaner_wrapper.sv
// Top level of the markup text cleaner with word wrap.
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_data (in_byte, in_last)
//  out     | output    | out_valid/out_stall | out_data (first, second, count, end)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (wrap_column)
// Each byte passes the queue pop, the token scan, the wrap-up and the end
// marker, besides its emitted bytes; a released hold line streams from the hold
// RAM at one byte per cycle while the output does not stall, and a space after a release takes a post step.
// Input bytes wait in a 4-entry queue; in_stall rises only when it is full.
// Reset puts wrap_column at 75 and the scanner in normal text mode.
// A stalled output holds the engine at its next emitted byte.
`default_nettype none
`include "assert_macros.svh"
module markup_text_cleaner_wrapper (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mtc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mtc_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [6:0]         cfg_data
);
    logic               q_valid;
    mtc_pkg::in_item_t  q_data;
    logic               q_pop;
    logic               emit_valid;
    mtc_pkg::emit_t     emit;
    logic               emit_ready;

    assign cfg_ready = 1'b1;

    mtc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    mtc_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .emit_valid(emit_valid), .emit(emit), .emit_ready(emit_ready)
    );

    mtc_pack u_pack (
        .clk(clk), .rst_n(rst_n),
        .emit_valid(emit_valid), .emit(emit), .emit_ready(emit_ready),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    `MTC_NEVER(a_count_range, clk, rst_n, out_valid && out_data.out_count == 2'd3)
    `MTC_ASSERT(a_empty_is_end, clk, rst_n, out_valid && out_data.out_count == 2'd0 |-> out_data.out_end)
    `MTC_ASSERT(a_second_zero, clk, rst_n, out_valid && out_data.out_count != 2'd2 |-> out_data.out_second == 8'h00)
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the markup text cleaner: directed and random text with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none

class text_scoreboard;
    localparam int HOLD_CAP = mtc_pkg::HOLD_CAP;
    localparam logic [1:0] SCAN_TEXT = 2'd0;
    localparam logic [1:0] SCAN_TAG = 2'd1;
    localparam logic [1:0] SCAN_DONE = 2'd2;

    logic [6:0] wrap_col;
    logic [7:0] held[$];
    logic [7:0] column;
    bit in_blank;
    bit space_held;
    logic [7:0] lookahead[$];
    logic [1:0] scan;
    logic [7:0] emitted[$];
    mtc_pkg::out_item_t pending_results[$];
    int errors;
    int results_seen;

    function new();
        wrap_col = mtc_pkg::WRAP_RESET;
        errors = 0;
        results_seen = 0;
        clear_text();
    endfunction

    function void clear_text();
        held.delete();
        lookahead.delete();
        column = 0;
        in_blank = 0;
        space_held = 0;
        scan = SCAN_TEXT;
    endfunction

    function void flush_held();
        foreach (held[i])
            emitted.push_back(held[i]);
        held.delete();
        space_held = 0;
    endfunction

    function void bump_column();
        if (column != 8'hFF)
            column++;
    endfunction

    function void put_text(logic [7:0] b);
        if (space_held && held.size() < HOLD_CAP)
        begin
            held.push_back(b);
            return;
        end
        if (space_held)
            flush_held();
        emitted.push_back(b);
    endfunction

    function void apply_wrap();
        int c;
        if (column > wrap_col && space_held && held.size() > 0)
        begin
            c = held.size() - 1;
            held[0] = mtc_pkg::CH_NL;
            column = (c > 255) ? 8'hFF : c[7:0];
            flush_held();
        end
    endfunction

    // 0 none, 1 full, 2 partial
    function int pattern_state(logic [7:0] w[$], int p, string pat);
        logic [7:0] c;
        for (int i = 0; i < pat.len() && p + i < w.size(); i++)
        begin
            c = w[p + i];
            if (c >= "A" && c <= "Z")
                c = c + 8'd32;
            if (c != pat[i])
                return 0;
        end
        return (w.size() - p >= pat.len()) ? 1 : 2;
    endfunction

    function void set_wrap(logic [6:0] v);
        wrap_col = v;
    endfunction

    function void note_input(mtc_pkg::in_item_t it);
        logic [7:0] w[$];
        int p;
        int s1, s2, s3, nl;
        logic [7:0] b;
        mtc_pkg::out_item_t r;
        int n;
        emitted.delete();
        p = 0;
        if (scan != SCAN_DONE)
        begin
            w = lookahead;
            w.push_back(it.in_byte);
        end
        while (p < w.size() && scan != SCAN_DONE)
        begin
            b = w[p];
            if (scan == SCAN_TAG)
            begin
                if (b == mtc_pkg::CH_NUL)
                    scan = SCAN_DONE;
                else if (b == mtc_pkg::CH_GT)
                    scan = SCAN_TEXT;
                p++;
            end
            else if (b == mtc_pkg::CH_NUL)
                scan = SCAN_DONE;
            else if (b == mtc_pkg::CH_SPACE || (b >= 8'h09 && b <= 8'h0D))
            begin
                if (!in_blank)
                begin
                    in_blank = 1;
                    if (space_held)
                        flush_held();
                    held.delete();
                    held.push_back(mtc_pkg::CH_SPACE);
                    space_held = 1;
                    bump_column();
                end
                p++;
            end
            else if (b == mtc_pkg::CH_AMP)
            begin
                s1 = pattern_state(w, p, "&amp;");
                s2 = pattern_state(w, p, "&lt;");
                s3 = pattern_state(w, p, "&gt;");
                if (!it.in_last && (s1 == 2 || s2 == 2 || s3 == 2))
                    break;
                in_blank = 0;
                apply_wrap();
                if (s1 == 1)
                begin
                    put_text("&");
                    p += 5;
                end
                else if (s2 == 1)
                begin
                    put_text("<");
                    p += 4;
                end
                else if (s3 == 1)
                begin
                    put_text(">");
                    p += 4;
                end
                else
                begin
                    put_text("&");
                    p++;
                end
                bump_column();
            end
            else if (b == mtc_pkg::CH_LT)
            begin
                s1 = pattern_state(w, p, "<br>");
                s2 = pattern_state(w, p, "<b>");
                if (!it.in_last && (s1 == 2 || s2 == 2))
                    break;
                in_blank = 0;
                apply_wrap();
                nl = (s1 == 1) ? 1 : (s2 == 1) ? 2 : 0;
                if (nl > 0)
                begin
                    if (space_held)
                        flush_held();
                    repeat (nl)
                        emitted.push_back(mtc_pkg::CH_NL);
                    column = 0;
                end
                p++;
                scan = SCAN_TAG;
            end
            else
            begin
                in_blank = 0;
                apply_wrap();
                put_text(b);
                bump_column();
                p++;
            end
        end
        lookahead.delete();
        if (scan != SCAN_DONE)
            while (p < w.size())
                lookahead.push_back(w[p++]);
        if (it.in_last)
            flush_held();
        n = (emitted.size() + 1) / 2;
        if (it.in_last && n == 0)
            n = 1;
        for (int i = 0; i < n; i++)
        begin
            r.out_count = (emitted.size() - 2 * i >= 2) ? 2'd2 : 2'(emitted.size() - 2 * i);
            r.out_first = (r.out_count >= 1) ? emitted[2 * i] : 8'h00;
            r.out_second = (r.out_count == 2) ? emitted[2 * i + 1] : 8'h00;
            r.out_end = it.in_last && (i == n - 1);
            pending_results.push_back(r);
        end
        if (it.in_last)
            clear_text();
    endfunction

    function void check_result(mtc_pkg::out_item_t got);
        mtc_pkg::out_item_t exp;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp = pending_results.pop_front();
        if (got.out_first !== exp.out_first)
        begin
            $error("out_first expected %h actual %h", exp.out_first, got.out_first);
            errors++;
        end
        if (got.out_second !== exp.out_second)
        begin
            $error("out_second expected %h actual %h", exp.out_second, got.out_second);
            errors++;
        end
        if (got.out_count !== exp.out_count)
        begin
            $error("out_count expected %0d actual %0d", exp.out_count, got.out_count);
            errors++;
        end
        if (got.out_end !== exp.out_end)
        begin
            $error("out_end expected %0d actual %0d", exp.out_end, got.out_end);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    mtc_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    mtc_pkg::out_item_t out_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [6:0] cfg_data = '0;

    text_scoreboard sb;
    int bytes_sent = 0;
    int texts_sent = 0;
    int out_wait = 0;
    bit stim_done = 0;

    markup_text_cleaner_wrapper dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    task automatic send_byte(logic [7:0] b, logic last);
        mtc_pkg::in_item_t it;
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap)
                @(posedge clk);
        end
        it.in_byte = b;
        it.in_last = last;
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        bytes_sent++;
        if (last)
            texts_sent++;
    endtask

    task automatic send_text(string s, logic with_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], with_last && i == s.len() - 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic write_wrap(logic [6:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_wrap(v);
        cfg_valid <= 0;
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 11))
            0: return mtc_pkg::CH_SPACE;
            1: return mtc_pkg::CH_SPACE;
            2: return 8'($urandom_range(9, 13));
            3: return mtc_pkg::CH_AMP;
            4: return mtc_pkg::CH_LT;
            5: return mtc_pkg::CH_GT;
            6: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    task automatic random_text(int len);
        string frag;
        int k;
        k = 0;
        while (k < len)
        begin
            case ($urandom_range(0, 9))
                0: frag = "&amp;";
                1: frag = "&LT;";
                2: frag = "&gt;";
                3: frag = "<br>";
                4: frag = "<B>";
                5: frag = "<i>";
                6: frag = "&am";
                default: frag = "";
            endcase
            if (frag.len() == 0)
            begin
                send_byte(random_char(), k == len - 1);
                k++;
            end
            else
                for (int i = 0; i < frag.len(); i++)
                begin
                    send_byte(frag[i], k == len - 1);
                    k++;
                    if (k >= len)
                        break;
                end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_data);
            out_wait = $urandom_range(0, 5);
        end
        if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        sb = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_text("Hello   World\t\n&AMP;&lt;&Gt; x", 1);
        send_text("a<BR>b<b>c<p>d&a", 1);
        send_text("zz\000ignored", 0);
        send_byte(8'hFF, 1);
        send_byte(8'h80, 0);
        send_byte(8'h7F, 1);
        drain();
        write_wrap(7'd8);
        send_text("one two three four", 1);
        drain();
        write_wrap(7'd120);
        random_text(70);
        drain();
        write_wrap(7'd8);
        for (int t = 0; t < 5; t++)
            random_text($urandom_range(10, 40));
        drain();
        write_wrap(7'($urandom_range(8, 120)));
        for (int t = 0; t < 4; t++)
            random_text($urandom_range(5, 30));
        drain();
        write_wrap(mtc_pkg::WRAP_RESET);
        while (bytes_sent < 310)
            random_text($urandom_range(5, 25));
        stim_done = 1;
        drain();
        $display("Sent %0d bytes in %0d texts, checked %0d results, wrap 8 to 120.",
                 bytes_sent, texts_sent, sb.results_seen);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/mtc_pkg.sv
hdl/mtc_front.sv
hdl/mtc_engine.sv
hdl/mtc_pack.sv
hdl/markup_text_cleaner_wrapper.sv
test/tb_top.sv
